// File: rtl/core/batc_pkg.sv
`default_nettype none

package batc_pkg;

    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned MINUTE_W    = 6;
    localparam int unsigned CFG_W       = 8;
    localparam int unsigned HOLD_W      = 4;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [HOLD_W-1:0]   HOLD_MAX    = 4'd15;

    localparam logic [CFG_W-1:0]  LOCKOUT_RST = 8'd10;
    localparam logic [CFG_W-1:0]  ASLEEP_RST  = 8'd10;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 4'd3;

    // lockout counter reset value, clipped to the counter maximum
    localparam int unsigned LOCKOUT_CNT_RST = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCKOUT = 2'd0,
        CFG_ASLEEP  = 2'd1,
        CFG_HOLD    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]  lockout_ticks;
        logic [CFG_W-1:0]  asleep_ticks;
        logic [HOLD_W-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic                snooze_button;
        logic                bed_occupied;
        logic                hour_button;
        logic                minute_button;
        logic [HOUR_W-1:0]   now_hour;
        logic [MINUTE_W-1:0] now_minute;
    } in_item_t;

    typedef struct packed {
        logic                ringing;
        logic                ring_started;
        logic                snoozed;
        logic                sleep_ended;
        logic                set_mode;
        logic                alarm_committed;
        logic [HOUR_W-1:0]   alarm_hour_out;
        logic [MINUTE_W-1:0] alarm_minute_out;
        logic [HOUR_W-1:0]   sleep_start_hour;
        logic [MINUTE_W-1:0] sleep_start_minute;
    } res_item_t;

    // stage handshake between the input register and the result register
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/batc_in_reg.sv
`default_nettype none

module batc_in_reg
    import batc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_item,
    input  wire logic       advance,
    output stage_ctl_t      ctl,
    output in_item_t        item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // take a new item when the stage is empty or moving on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/batc_core.sv
`default_nettype none

module batc_core
    import batc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl,
    input  wire in_item_t   item,
    input  wire cfg_t       cfg,
    output res_item_t       res
);

    localparam int unsigned CW    = COUNT_BITS;
    localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] LOCK_CNT_RST =
        (LOCKOUT_CNT_RST > ((1 << COUNT_BITS) - 1)) ? CNT_MAX : CW'(LOCKOUT_CNT_RST);

    logic                on_bed_reg,        on_bed_next;
    logic                alarm_on_reg,      alarm_on_next;
    logic [CW-1:0]       lockout_reg,       lockout_next;
    logic [CW-1:0]       bed_cnt_reg,       bed_cnt_next;
    logic [HOLD_W-1:0]   hold_cnt_reg,      hold_cnt_next;
    logic                button_held_reg,   button_held_next;
    logic                setting_reg,       setting_next;
    logic [HOUR_W-1:0]   alarm_hour_reg,    alarm_hour_next;
    logic [MINUTE_W-1:0] alarm_minute_reg,  alarm_minute_next;
    logic [HOUR_W-1:0]   start_hour_reg,    start_hour_next;
    logic [MINUTE_W-1:0] start_minute_reg,  start_minute_next;

    logic          fire;
    logic          started;
    logic          snoozed;
    logic          ended;
    logic          committed;
    logic          match;
    logic [CW-1:0] lock_mid;
    logic [CW-1:0] bed_mid;
    logic [CW-1:0] lock_rearm;
    logic [CMP_W-1:0] lock_cfg_ext;
    logic [HOLD_W-1:0] hold_inc;

    assign fire = ctl.valid && ctl.advance;

    assign match = (alarm_hour_reg == item.now_hour) &&
                   (alarm_minute_reg == item.now_minute) &&
                   (CMP_W'(lockout_reg) > CMP_W'(cfg.lockout_ticks));

    // lockout value after leaving the bed: threshold plus one, saturated
    assign lock_cfg_ext = CMP_W'(cfg.lockout_ticks);
    assign lock_rearm   = (lock_cfg_ext >= CMP_W'(CNT_MAX)) ? CNT_MAX :
                          CW'(lock_cfg_ext + CMP_W'(1));

    assign hold_inc = (hold_cnt_reg == HOLD_MAX) ? HOLD_MAX : hold_cnt_reg + 1'b1;

    always_comb
    begin
        started           = 1'b0;
        snoozed           = 1'b0;
        ended             = 1'b0;
        committed         = 1'b0;
        on_bed_next       = on_bed_reg;
        alarm_on_next     = alarm_on_reg;
        lock_mid          = lockout_reg;
        start_hour_next   = start_hour_reg;
        start_minute_next = start_minute_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        setting_next      = setting_reg;
        hold_cnt_next     = hold_cnt_reg;
        button_held_next  = button_held_reg;

        // ring check, then snooze while ringing
        if (on_bed_reg)
        begin
            if (match)
            begin
                alarm_on_next = 1'b1;
                started       = 1'b1;
            end
            if (alarm_on_next && item.snooze_button)
            begin
                lock_mid = '0;
                snoozed  = 1'b1;
            end
        end

        lockout_next = lock_mid;
        if (alarm_on_next && (lock_mid != CNT_MAX))
        begin
            lockout_next = lock_mid + 1'b1;
        end

        bed_mid = bed_cnt_reg;
        if (on_bed_reg && (bed_cnt_reg != CNT_MAX))
        begin
            bed_mid = bed_cnt_reg + 1'b1;
        end
        bed_cnt_next = bed_mid;

        // bed edges
        if (item.bed_occupied && !on_bed_reg)
        begin
            on_bed_next       = 1'b1;
            start_hour_next   = item.now_hour;
            start_minute_next = item.now_minute;
            if (bed_mid != CNT_MAX)
            begin
                bed_cnt_next = bed_mid + 1'b1;
            end
        end
        else if (!item.bed_occupied && on_bed_reg)
        begin
            on_bed_next = 1'b0;
            if (CMP_W'(bed_mid) > CMP_W'(cfg.asleep_ticks))
            begin
                ended = 1'b1;
                if (alarm_on_next)
                begin
                    alarm_on_next = 1'b0;
                    lockout_next  = lock_rearm;
                end
            end
            bed_cnt_next = '0;
        end

        // step the alarm time in set mode
        if (setting_reg)
        begin
            if (item.hour_button)
            begin
                alarm_hour_next = (alarm_hour_reg >= HOUR_LAST) ? '0 :
                                  alarm_hour_reg + 1'b1;
            end
            if (item.minute_button)
            begin
                alarm_minute_next = (alarm_minute_reg >= MINUTE_LAST) ? '0 :
                                    alarm_minute_reg + 1'b1;
            end
        end

        // snooze hold into set mode, fresh press commits
        if (item.snooze_button)
        begin
            if (setting_reg && !button_held_reg)
            begin
                setting_next = 1'b0;
                committed    = 1'b1;
            end
            else
            begin
                hold_cnt_next    = hold_inc;
                button_held_next = 1'b1;
                if (hold_inc == cfg.hold_ticks)
                begin
                    setting_next = 1'b1;
                end
            end
        end
        else
        begin
            button_held_next = 1'b0;
            hold_cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_bed_reg       <= 1'b0;
            alarm_on_reg     <= 1'b0;
            lockout_reg      <= LOCK_CNT_RST;
            bed_cnt_reg      <= '0;
            hold_cnt_reg     <= '0;
            button_held_reg  <= 1'b0;
            setting_reg      <= 1'b0;
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
            start_hour_reg   <= '0;
            start_minute_reg <= '0;
        end
        else if (fire)
        begin
            on_bed_reg       <= on_bed_next;
            alarm_on_reg     <= alarm_on_next;
            lockout_reg      <= lockout_next;
            bed_cnt_reg      <= bed_cnt_next;
            hold_cnt_reg     <= hold_cnt_next;
            button_held_reg  <= button_held_next;
            setting_reg      <= setting_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            start_hour_reg   <= start_hour_next;
            start_minute_reg <= start_minute_next;
        end
    end

    assign res.ringing            = alarm_on_next;
    assign res.ring_started       = started;
    assign res.snoozed            = snoozed;
    assign res.sleep_ended        = ended;
    assign res.set_mode           = setting_next;
    assign res.alarm_committed    = committed;
    assign res.alarm_hour_out     = alarm_hour_next;
    assign res.alarm_minute_out   = alarm_minute_next;
    assign res.sleep_start_hour   = start_hour_next;
    assign res.sleep_start_minute = start_minute_next;

endmodule

`default_nettype wire

// File: rtl/core/batc_out_reg.sv
`default_nettype none

module batc_out_reg
    import batc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stage_ctl_t ctl,
    input  wire res_item_t  res,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic            advance,
    output res_item_t       out_item
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    // the upstream stage may move on when this register is empty or drained
    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? ctl.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid && ctl.advance)
        begin
            item_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/bed_alarm_tick_controller_unit.sv
// Bedside alarm tick controller.
// Each item on the input channel is one one-second tick: snooze, bed, hour and
// minute button levels plus the current clock hour and minute. Each item gives
// exactly one result item: ringing and set-mode status, single-tick event flags
// (ring started, snoozed, sleep ended, alarm committed), the alarm setting and
// the time the occupant last got onto the bed.
// Both channels use valid/ready; an item moves when valid and ready are high
// at a rising edge. The item first lands in the input register, then one
// pass of update logic writes the state and the result register. Throughput
// is one item per cycle while out_ready stays high, set by the single update pass.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; in_ready drops only when both are full.
// The configuration port writes snooze_lockout_ticks (0), asleep_ticks (1)
// and hold_ticks (2) on any edge with cfg_we high; other indexes are ignored.
// Write it only while no item is in flight.
// Reset (rst_n low, asynchronous) empties both registers, loads the register
// defaults 10, 10 and 3, clears all state and sets the lockout counter to 31
// (clipped to the counter maximum) so the alarm may ring at once.
`default_nettype none

module bed_alarm_tick_controller_unit
    import batc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 snooze_button,
    input  wire logic                 bed_occupied,
    input  wire logic                 hour_button,
    input  wire logic                 minute_button,
    input  wire logic [HOUR_W-1:0]    now_hour,
    input  wire logic [MINUTE_W-1:0]  now_minute,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      ringing,
    output logic                      ring_started,
    output logic                      snoozed,
    output logic                      sleep_ended,
    output logic                      set_mode,
    output logic                      alarm_committed,
    output logic [HOUR_W-1:0]         alarm_hour_out,
    output logic [MINUTE_W-1:0]       alarm_minute_out,
    output logic [HOUR_W-1:0]         sleep_start_hour,
    output logic [MINUTE_W-1:0]       sleep_start_minute
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    in_item_t   in_item;
    in_item_t   stage_item;
    stage_ctl_t stage_ctl;
    res_item_t  res;
    res_item_t  out_item;
    logic       advance;

    // configuration registers: write on enable, ignore unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCKOUT: cfg_next.lockout_ticks = cfg_data;
                CFG_ASLEEP:  cfg_next.asleep_ticks  = cfg_data;
                CFG_HOLD:    cfg_next.hold_ticks    = cfg_data[HOLD_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ticks <= LOCKOUT_RST;
            cfg_reg.asleep_ticks  <= ASLEEP_RST;
            cfg_reg.hold_ticks    <= HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_item.snooze_button = snooze_button;
    assign in_item.bed_occupied  = bed_occupied;
    assign in_item.hour_button   = hour_button;
    assign in_item.minute_button = minute_button;
    assign in_item.now_hour      = now_hour;
    assign in_item.now_minute    = now_minute;

    // hold the incoming tick
    batc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .ctl      (stage_ctl),
        .item     (stage_item)
    );

    // one update pass per tick: state advances as the item moves on
    batc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (stage_ctl),
        .item  (stage_item),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // hold the result until the receiver takes it
    batc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stage_ctl),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .advance   (advance),
        .out_item  (out_item)
    );

    assign ringing            = out_item.ringing;
    assign ring_started       = out_item.ring_started;
    assign snoozed            = out_item.snoozed;
    assign sleep_ended        = out_item.sleep_ended;
    assign set_mode           = out_item.set_mode;
    assign alarm_committed    = out_item.alarm_committed;
    assign alarm_hour_out     = out_item.alarm_hour_out;
    assign alarm_minute_out   = out_item.alarm_minute_out;
    assign sleep_start_hour   = out_item.sleep_start_hour;
    assign sleep_start_minute = out_item.sleep_start_minute;

    // both registers full and the receiver stalled: no new item may enter
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_ctl.valid && out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages full and stalled");

    // a commit leaves set mode in the same tick
    a_commit_leaves_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alarm_committed) |-> !set_mode)
        else $error("alarm committed while still in set mode");

    // stepped alarm time stays on the clock face
    a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((alarm_hour_out <= HOUR_LAST) && (alarm_minute_out <= MINUTE_LAST)))
        else $error("alarm time out of range");

    // an empty result register lets the input stage move on
    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_ctl.valid && !out_valid) |=> out_valid)
        else $error("pending item not moved into empty result register");

endmodule

`default_nettype wire

// File: tb/batc_tick_checker.sv
`default_nettype none

// Watches both channels of the alarm tick controller, keeps its own copy of
// the controller state and registers, and compares every result item with
// the oldest outstanding prediction.
module batc_tick_checker
    import batc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire in_item_t             tick,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire res_item_t            res,
    output int                        mismatches,
    output int                        pending
);

    localparam logic [COUNT_BITS-1:0] CNT_TOP = '1;

    // register copies
    logic [CFG_W-1:0]  quiet_cfg;
    logic [CFG_W-1:0]  asleep_cfg;
    logic [HOLD_W-1:0] hold_cfg;

    // controller state copy
    logic                  occupied;
    logic                  alarm_live;
    logic [COUNT_BITS-1:0] quiet_count;
    logic [COUNT_BITS-1:0] lie_count;
    logic [HOLD_W-1:0]     press_count;
    logic                  press_seen;
    logic                  editing;
    logic [HOUR_W-1:0]     wake_h;
    logic [MINUTE_W-1:0]   wake_m;
    logic [HOUR_W-1:0]     lay_h;
    logic [MINUTE_W-1:0]   lay_m;

    res_item_t due_results[$];
    int        results_checked = 0;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_TOP) ? v : v + 1'b1;
    endfunction

    task automatic report_fault(input string msg);
        $display("[%0t] checker: result %0d: %s", $realtime, results_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic clear_state();
        quiet_cfg   = LOCKOUT_RST;
        asleep_cfg  = ASLEEP_RST;
        hold_cfg    = HOLD_RST;
        occupied    = 1'b0;
        alarm_live  = 1'b0;
        quiet_count = (LOCKOUT_CNT_RST > CNT_TOP) ? CNT_TOP : COUNT_BITS'(LOCKOUT_CNT_RST);
        lie_count   = '0;
        press_count = '0;
        press_seen  = 1'b0;
        editing     = 1'b0;
        wake_h      = '0;
        wake_m      = '0;
        lay_h       = '0;
        lay_m       = '0;
    endtask

    // one second of controller behaviour
    task automatic advance_tick(input in_item_t t, output res_item_t r);
        logic rang;
        logic hushed;
        logic woke;
        logic saved;
        rang   = 1'b0;
        hushed = 1'b0;
        woke   = 1'b0;
        saved  = 1'b0;
        if (occupied)
        begin
            if (wake_h == t.now_hour && wake_m == t.now_minute && quiet_count > quiet_cfg)
            begin
                alarm_live = 1'b1;
                rang       = 1'b1;
            end
            if (alarm_live && t.snooze_button)
            begin
                quiet_count = '0;
                hushed      = 1'b1;
            end
        end
        if (alarm_live)
            quiet_count = bump(quiet_count);
        if (occupied)
            lie_count = bump(lie_count);

        if (t.bed_occupied && !occupied)
        begin
            occupied  = 1'b1;
            lay_h     = t.now_hour;
            lay_m     = t.now_minute;
            lie_count = bump(lie_count);
        end
        else if (!t.bed_occupied && occupied)
        begin
            occupied = 1'b0;
            if (lie_count > asleep_cfg)
            begin
                woke = 1'b1;
                if (alarm_live)
                begin
                    alarm_live = 1'b0;
                    // re-arm so the alarm may ring again at once
                    if (quiet_cfg >= CNT_TOP)
                        quiet_count = CNT_TOP;
                    else
                        quiet_count = quiet_cfg + 1'b1;
                end
            end
            lie_count = '0;
        end

        if (editing)
        begin
            if (t.hour_button)
                wake_h = (wake_h >= HOUR_LAST) ? '0 : wake_h + 1'b1;
            if (t.minute_button)
                wake_m = (wake_m >= MINUTE_LAST) ? '0 : wake_m + 1'b1;
        end

        if (t.snooze_button)
        begin
            if (editing && !press_seen)
            begin
                editing = 1'b0;
                saved   = 1'b1;
            end
            else
            begin
                press_count = (press_count == HOLD_MAX) ? press_count : press_count + 1'b1;
                press_seen  = 1'b1;
                if (press_count == hold_cfg)
                    editing = 1'b1;
            end
        end
        else
        begin
            press_seen  = 1'b0;
            press_count = '0;
        end

        r = {alarm_live, rang, hushed, woke, editing, saved, wake_h, wake_m, lay_h, lay_m};
    endtask

    always @(posedge clk)
    begin : watch
        res_item_t want;
        res_item_t fresh;
        if (!rst_n)
        begin
            clear_state();
            due_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_fault("result item with no tick outstanding");
                else
                begin
                    want = due_results.pop_front();
                    check_field("ringing", res.ringing, want.ringing);
                    check_field("ring_started", res.ring_started, want.ring_started);
                    check_field("snoozed", res.snoozed, want.snoozed);
                    check_field("sleep_ended", res.sleep_ended, want.sleep_ended);
                    check_field("set_mode", res.set_mode, want.set_mode);
                    check_field("alarm_committed", res.alarm_committed, want.alarm_committed);
                    check_field("alarm_hour_out", res.alarm_hour_out, want.alarm_hour_out);
                    check_field("alarm_minute_out", res.alarm_minute_out,
                                want.alarm_minute_out);
                    check_field("sleep_start_hour", res.sleep_start_hour,
                                want.sleep_start_hour);
                    check_field("sleep_start_minute", res.sleep_start_minute,
                                want.sleep_start_minute);
                end
                results_checked++;
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_LOCKOUT: quiet_cfg  = cfg_data;
                    CFG_ASLEEP:  asleep_cfg = cfg_data;
                    CFG_HOLD:    hold_cfg   = cfg_data[HOLD_W-1:0];
                    default:     ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                advance_tick(tick, fresh);
                due_results.push_back(fresh);
            end
        end
        pending = due_results.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_bed_alarm_tick_controller_unit.sv
`default_nettype none

// Top of the alarm tick controller bench. This module only makes stimulus
// and gives the verdict; all prediction and comparison lives in the checker.
module tb_bed_alarm_tick_controller_unit;
    import batc_pkg::*;

    localparam int unsigned COUNT_BITS   = 8;
    localparam int          TARGET_TICKS = 1175;
    localparam int          PHASE_TICKS  = 115;
    localparam int          CYCLE_LIMIT  = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             tick;
    logic                 out_valid;
    logic                 out_ready;

    logic                 ringing;
    logic                 ring_started;
    logic                 snoozed;
    logic                 sleep_ended;
    logic                 set_mode;
    logic                 alarm_committed;
    logic [HOUR_W-1:0]    alarm_hour_out;
    logic [MINUTE_W-1:0]  alarm_minute_out;
    logic [HOUR_W-1:0]    sleep_start_hour;
    logic [MINUTE_W-1:0]  sleep_start_minute;
    res_item_t            res_bus;

    int mismatches;
    int pending;

    // stimulus bookkeeping
    bit                  calm = 1'b0;      // no idling on either side while set
    int                  ticks_sent = 0;
    int                  phases_run = 0;
    int                  hold_now = HOLD_RST;
    logic [HOUR_W-1:0]   seen_h = '0;      // last alarm time the block reported
    logic [MINUTE_W-1:0] seen_m = '0;
    int                  rings_heard = 0;
    int                  snoozes_heard = 0;
    int                  sleeps_heard = 0;
    int                  commits_heard = 0;
    int                  cycle_count = 0;

    assign res_bus = {ringing, ring_started, snoozed, sleep_ended, set_mode, alarm_committed,
                      alarm_hour_out, alarm_minute_out, sleep_start_hour, sleep_start_minute};

    bed_alarm_tick_controller_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .snooze_button     (tick.snooze_button),
        .bed_occupied      (tick.bed_occupied),
        .hour_button       (tick.hour_button),
        .minute_button     (tick.minute_button),
        .now_hour          (tick.now_hour),
        .now_minute        (tick.now_minute),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ringing           (ringing),
        .ring_started      (ring_started),
        .snoozed           (snoozed),
        .sleep_ended       (sleep_ended),
        .set_mode          (set_mode),
        .alarm_committed   (alarm_committed),
        .alarm_hour_out    (alarm_hour_out),
        .alarm_minute_out  (alarm_minute_out),
        .sleep_start_hour  (sleep_start_hour),
        .sleep_start_minute(sleep_start_minute)
    );

    batc_tick_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tick      (tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res_bus),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: count cycles and give up well beyond the slowest good run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d ticks outstanding", cycle_count, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: stall at random, except during the calm stretch.
    initial out_ready = 1'b0;
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 22);

    // Track the alarm time the block reports, so nights aim at it, and tally
    // the events for the closing summary.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            seen_h <= alarm_hour_out;
            seen_m <= alarm_minute_out;
            rings_heard   <= rings_heard + ring_started;
            snoozes_heard <= snoozes_heard + snoozed;
            sleeps_heard  <= sleeps_heard + sleep_ended;
            commits_heard <= commits_heard + alarm_committed;
        end
    end

    function automatic logic [HOUR_W-1:0] pick_hour();
        // mostly a real clock hour, now and then anything the field holds
        if ($urandom_range(0, 9) == 0)
            return HOUR_W'($urandom_range(0, 31));
        return HOUR_W'($urandom_range(0, 23));
    endfunction

    function automatic logic [MINUTE_W-1:0] pick_minute();
        if ($urandom_range(0, 9) == 0)
            return MINUTE_W'($urandom_range(0, 63));
        return MINUTE_W'($urandom_range(0, 59));
    endfunction

    // Present one tick item and hold it until accepted. Entered and left at a
    // falling edge; valid stays high afterwards unless the next call idles.
    task automatic send_tick(input logic s, input logic b, input logic h, input logic m,
                             input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mn);
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        tick     <= {s, b, h, m, hr, mn};
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Write all three registers on consecutive edges; only call when settled.
    task automatic program_regs(input int lockout, input int asleep, input int hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOCKOUT;
        cfg_data  <= CFG_W'(lockout);
        @(negedge clk);
        cfg_index <= CFG_ASLEEP;
        cfg_data  <= CFG_W'(asleep);
        @(negedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data  <= CFG_W'(hold);
        @(negedge clk);
        cfg_we    <= 1'b0;
        hold_now  = hold & 4'hF;
    endtask

    // A stay on the bed: the clock sits on the alarm time about half of the
    // ticks, with scattered snooze and step presses, then the occupant leaves.
    task automatic run_night(input int len);
        int                  k;
        int                  roll;
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mn;
        for (k = 0; k < len; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                hr = seen_h;
                mn = seen_m;
            end
            else
            begin
                hr = pick_hour();
                mn = pick_minute();
            end
            send_tick($urandom_range(0, 99) < 12, 1'b1, $urandom_range(0, 9) == 0,
                      $urandom_range(0, 9) == 0, hr, mn);
        end
        repeat ($urandom_range(1, 3))
            send_tick($urandom_range(0, 9) == 0, 1'b0, 1'b0, 1'b0, pick_hour(), pick_minute());
    endtask

    // Hold snooze into set mode, step the alarm, then commit with a fresh
    // press. Now and then the hold falls one tick short.
    task automatic run_setting();
        int   n;
        int   steps;
        logic bed;
        bed = 1'($urandom_range(0, 1));
        n   = (hold_now == 0) ? $urandom_range(1, 4) : hold_now + $urandom_range(0, 2);
        if (hold_now > 1 && $urandom_range(0, 4) == 0)
            n = hold_now - 1;
        repeat (n)
            send_tick(1'b1, bed, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pick_hour(), pick_minute());
        // mostly a few steps; sometimes enough to wrap the hour and minute
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
        repeat (steps)
            send_tick(1'b0, bed, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pick_hour(), pick_minute());
        send_tick(1'b1, bed, 1'b0, 1'b0, pick_hour(), pick_minute());
        send_tick(1'b0, bed, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  pick_hour(), pick_minute());
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      HOUR_W'($urandom_range(0, 31)), MINUTE_W'($urandom_range(0, 63)));
    endtask

    // Short directed opening at the reset register values (lockout 10,
    // asleep 10, hold 3) with the alarm at 00:00.
    task automatic run_directed();
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59);
        // step buttons outside set mode do nothing; clock out of range
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 5'd31, 6'd63);
        // get on the bed at an impossible time: stored as sleep start anyway
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 5'd31, 6'd63);
        // ring, then ring again while already ringing
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0);
        // snooze while ringing, then the lockout holds the ring off
        send_tick(1'b1, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 5'd0, 6'd0);
        repeat (8)
            send_tick(1'b0, 1'b1, 1'b0, 1'b0, 5'd0, 6'd1);
        // leave the bed while ringing and asleep: sleep ends, alarm stops
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd2);
        // hold snooze into set mode and keep holding: no commit yet
        repeat (4)
            send_tick(1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 6'd3);
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 5'd0, 6'd3);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 5'd0, 6'd3);
        // fresh press commits
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 6'd4);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 6'd4);
    endtask

    initial
    begin : stimulus
        int phase;
        int budget;
        int pick;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_LOCKOUT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        tick      = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        for (phase = 0; ticks_sent < TARGET_TICKS; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1:       program_regs(0, 0, 1);
                    2:       program_regs(254, 254, 14);
                    3:       program_regs(255, 255, 0);
                    4:       program_regs(1, 2, 15);
                    default:
                        program_regs(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, 15),
                                     $urandom_range(0, 25),
                                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                 : $urandom_range(1, 6));
                endcase
            end
            phases_run++;
            // the extreme-threshold phase runs with no random idling on either side
            calm   = (phase == 2);
            budget = ticks_sent + PHASE_TICKS;
            if (phase == 2)
                run_night(300);
            while (ticks_sent < budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    settle();
                else if (pick < 50)
                    run_night(($urandom_range(0, 19) == 0) ? $urandom_range(60, 270)
                                                           : $urandom_range(2, 40));
                else if (pick < 75)
                    run_setting();
                else
                    run_noise();
            end
        end

        // drain, then keep the clock running so any stray items show
        settle();
        calm = 1'b0;
        repeat (8) @(posedge clk);

        $display("covered %0d tick items over %0d register settings in %0d cycles",
                 ticks_sent, phases_run, cycle_count);
        $display("seen: %0d ring starts, %0d snoozes, %0d sleep ends, %0d alarm commits",
                 rings_heard, snoozes_heard, sleeps_heard, commits_heard);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
